/* design/assert_macros.svh */
// assertion macros used by the detector core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BDCD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bdcd assertion failed");

`define BDCD_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bdcd forbidden condition seen");

`else

`define BDCD_ASSERT(label, clk, rst, prop)

`define BDCD_NEVER(label, clk, rst, cond)

`endif

`endif

/* design/bdcd_pkg.sv */
// types, codes and reset values for the button debounce and click detector
`timescale 1ns / 1ps

package bdcd_pkg;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_PRESSING  = 5'b00010,
      PH_PRESSED   = 5'b00100,
      PH_RELEASING = 5'b01000,
      PH_WAIT      = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PRESSED  = 3'd1,
      EV_RELEASED = 3'd2,
      EV_LONG     = 3'd3,
      EV_REPEAT   = 3'd4,
      EV_CLICK    = 3'd5,
      EV_MULTI    = 3'd6
   } event_type;

   // register indexes on the csr port
   localparam logic [2:0] REG_PRESS_LEVEL     = 3'd0;
   localparam logic [2:0] REG_DEBOUNCE_TIME   = 3'd1;
   localparam logic [2:0] REG_LONG_PRESS_TIME = 3'd2;
   localparam logic [2:0] REG_REPEAT_PERIOD   = 3'd3;
   localparam logic [2:0] REG_MAX_CLICKS      = 3'd4;
   localparam logic [2:0] REG_CLICK_GAP_TIME  = 3'd5;

   localparam int unsigned CSR_ADDR_WIDTH = 5;

   localparam logic        PRESS_LEVEL_RESET     = 1'b1;
   localparam logic [15:0] DEBOUNCE_TIME_RESET   = 16'd20;
   localparam logic [15:0] LONG_PRESS_TIME_RESET = 16'd1500;
   localparam logic [15:0] REPEAT_PERIOD_RESET   = 16'd0;
   localparam logic [7:0]  MAX_CLICKS_RESET      = 8'd1;
   localparam logic [15:0] CLICK_GAP_TIME_RESET  = 16'd300;

   localparam logic [7:0]  CLICK_COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic        press_level;
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] repeat_period;
      logic [7:0]  max_clicks;
      logic [15:0] click_gap_time;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] edge_time;
      logic [31:0] press_start;
      logic        long_done;
      logic [31:0] repeat_deadline;
      logic [7:0]  click_count;
   } state_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  click_total;
      logic        held;
      logic [31:0] hold_duration;
      logic        last;
   } result_type;

   // event for handing over a tap count: none, single click or multi-click
   function automatic event_type click_event(input logic [7:0] count);
      event_type ev;
      ev = EV_NONE;
      if (count == 8'd1) begin
         ev = EV_CLICK;
      end else if (count >= 8'd2) begin
         ev = EV_MULTI;
      end
      return ev;
   endfunction

endpackage

/* design/bdcd_fsm.sv */
// next-state and result logic for one poll of the button
`timescale 1ns / 1ps

module bdcd_fsm
   import bdcd_pkg::*;
(
   input  cfg_type     cfg,
   input  state_type   state_cur,
   input  logic        pin_level,
   input  logic [31:0] now_time,
   output state_type   state_nxt,
   output result_type  res_first,
   output result_type  res_second,
   output logic        two_results
);

   logic        pressed;
   logic [31:0] dt_edge;
   logic [31:0] dt_press;
   logic [31:0] dt_repeat;
   logic [7:0]  count_inc;
   logic        long_hit;
   event_type   ev;
   event_type   ev2;
   logic [7:0]  clicks;
   logic [7:0]  clicks2;
   logic        two;
   logic        held;
   logic [31:0] hold;
   state_type   nxt;

   assign pressed   = (pin_level == cfg.press_level);
   assign dt_edge   = now_time - state_cur.edge_time;
   assign dt_press  = now_time - state_cur.press_start;
   assign dt_repeat = now_time - state_cur.repeat_deadline;
   assign count_inc = (state_cur.click_count != CLICK_COUNT_MAX) ?
                      state_cur.click_count + 8'd1 : state_cur.click_count;
   assign long_hit  = !state_cur.long_done && (cfg.long_press_time != 16'd0) &&
                      (dt_press >= {16'd0, cfg.long_press_time});

   always_comb begin
      nxt     = state_cur;
      ev      = EV_NONE;
      ev2     = EV_NONE;
      clicks  = 8'd0;
      clicks2 = 8'd0;
      two     = 1'b0;
      case (state_cur.phase)
         PH_PRESSING: begin
            if (!pressed) begin
               nxt.phase = PH_IDLE;
            end else if (dt_edge >= {16'd0, cfg.debounce_time}) begin
               nxt.phase       = PH_PRESSED;
               nxt.press_start = now_time;
               nxt.long_done   = 1'b0;
               nxt.repeat_deadline = (cfg.repeat_period != 16'd0) ?
                                     now_time + {16'd0, cfg.repeat_period} : 32'd0;
               ev = EV_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (!pressed) begin
               nxt.phase     = PH_RELEASING;
               nxt.edge_time = now_time;
            end else begin
               if (long_hit) begin
                  nxt.long_done = 1'b1;
                  ev            = EV_LONG;
               end
               // repeat runs only while the deadline is reached (half-range test)
               if (!long_hit && !state_cur.long_done && (cfg.repeat_period != 16'd0) &&
                   (state_cur.repeat_deadline != 32'd0) && !dt_repeat[31]) begin
                  nxt.repeat_deadline = state_cur.repeat_deadline +
                                        {16'd0, cfg.repeat_period};
                  ev = EV_REPEAT;
               end
            end
         end
         PH_RELEASING: begin
            if (pressed) begin
               nxt.phase = PH_PRESSED;
            end else if (dt_edge >= {16'd0, cfg.debounce_time}) begin
               ev = EV_RELEASED;
               if (!state_cur.long_done) begin
                  if (cfg.max_clicks <= 8'd1) begin
                     ev2             = click_event(count_inc);
                     clicks2         = count_inc;
                     two             = (ev2 != EV_NONE);
                     nxt.click_count = 8'd0;
                     nxt.phase       = PH_IDLE;
                  end else begin
                     nxt.click_count = count_inc;
                     nxt.phase       = PH_WAIT;
                     nxt.edge_time   = now_time;
                  end
               end else begin
                  // a long hold ends without a click
                  nxt.click_count = 8'd0;
                  nxt.phase       = PH_IDLE;
               end
            end
         end
         PH_WAIT: begin
            if (pressed) begin
               nxt.phase     = PH_PRESSING;
               nxt.edge_time = now_time;
            end else if (dt_edge >= {16'd0, cfg.click_gap_time}) begin
               ev              = click_event(state_cur.click_count);
               clicks          = state_cur.click_count;
               nxt.click_count = 8'd0;
               nxt.phase       = PH_IDLE;
            end
         end
         default: begin
            // idle, and any stray code behaves as idle
            if (pressed) begin
               nxt.phase     = PH_PRESSING;
               nxt.edge_time = now_time;
            end else begin
               nxt.phase = PH_IDLE;
            end
         end
      endcase
   end

   assign held = (nxt.phase == PH_PRESSED) || (nxt.phase == PH_RELEASING);
   assign hold = held ? (now_time - nxt.press_start) : 32'd0;

   assign state_nxt   = nxt;
   assign two_results = two;

   assign res_first.event_res     = ev;
   assign res_first.click_total   = two ? 8'd0 : clicks;
   assign res_first.held          = held;
   assign res_first.hold_duration = hold;
   assign res_first.last          = !two;

   assign res_second.event_res     = ev2;
   assign res_second.click_total   = clicks2;
   assign res_second.held          = held;
   assign res_second.hold_duration = hold;
   assign res_second.last          = 1'b1;

endmodule

/* design/button_debounce_click_detector_core.sv */
// top level of the button debounce, long-press and multi-click detector
//
//  port group | direction | carries
//  req_*      | in        | one poll item: raw pin level and millisecond timestamp
//  rsp_*      | out       | one or two result items per poll: event, clicks, hold
//  csr_*      | in/out    | apb-style register access, six registers at 4*i
//
// a poll is captured in the input register, then the state update and its
// results go to the output register: one poll per cycle while rsp_stall is
// low and no second item waits. a release that also hands over a click gives a
// second item, held in a spare register, and the input stalls until it is sent.
// reset is synchronous and returns the machine to idle and the registers to
// their defaults. rsp_stall holds the output item and backs up into req_stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_debounce_click_detector_core
   import bdcd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_pin_level,
   input  logic [31:0]               req_now_time,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_event_res,
   output logic [7:0]                rsp_click_total,
   output logic                      rsp_held,
   output logic [31:0]               rsp_hold_duration,
   output logic                      rsp_last,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   state_type   state_ff, state_in;
   logic        in_valid_ff, in_valid_in;
   logic        in_pin_ff, in_pin_in;
   logic [31:0] in_now_ff, in_now_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        pend_valid_ff, pend_valid_in;
   result_type  pend_ff, pend_in;

   state_type   state_nxt;
   result_type  res_first;
   result_type  res_second;
   logic        two_results;
   logic        out_free;
   logic        fire;
   logic        req_take;
   logic        csr_wr;
   logic [2:0]  csr_index;
   logic        out_click;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_PRESS_LEVEL:     cfg_in.press_level     = csr_pwdata[0];
            REG_DEBOUNCE_TIME:   cfg_in.debounce_time   = csr_pwdata[15:0];
            REG_LONG_PRESS_TIME: cfg_in.long_press_time = csr_pwdata[15:0];
            REG_REPEAT_PERIOD:   cfg_in.repeat_period   = csr_pwdata[15:0];
            REG_MAX_CLICKS:      cfg_in.max_clicks      = csr_pwdata[7:0];
            REG_CLICK_GAP_TIME:  cfg_in.click_gap_time  = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PRESS_LEVEL:     csr_prdata = {31'd0, cfg_ff.press_level};
         REG_DEBOUNCE_TIME:   csr_prdata = {16'd0, cfg_ff.debounce_time};
         REG_LONG_PRESS_TIME: csr_prdata = {16'd0, cfg_ff.long_press_time};
         REG_REPEAT_PERIOD:   csr_prdata = {16'd0, cfg_ff.repeat_period};
         REG_MAX_CLICKS:      csr_prdata = {24'd0, cfg_ff.max_clicks};
         REG_CLICK_GAP_TIME:  csr_prdata = {16'd0, cfg_ff.click_gap_time};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // ---------------- handshake ----------------
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free && !pend_valid_ff;
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign in_pin_in   = req_take ? req_pin_level : in_pin_ff;
   assign in_now_in   = req_take ? req_now_time : in_now_ff;

   bdcd_fsm u_fsm (
      .cfg         (cfg_ff),
      .state_cur   (state_ff),
      .pin_level   (in_pin_ff),
      .now_time    (in_now_ff),
      .state_nxt   (state_nxt),
      .res_first   (res_first),
      .res_second  (res_second),
      .two_results (two_results)
   );

   assign state_in = fire ? state_nxt : state_ff;

   // output register with a spare slot for the second item of a poll
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (fire) begin
            out_valid_in  = 1'b1;
            out_in        = res_first;
            pend_valid_in = two_results;
            pend_in       = res_second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_level     <= PRESS_LEVEL_RESET;
         cfg_ff.debounce_time   <= DEBOUNCE_TIME_RESET;
         cfg_ff.long_press_time <= LONG_PRESS_TIME_RESET;
         cfg_ff.repeat_period   <= REPEAT_PERIOD_RESET;
         cfg_ff.max_clicks      <= MAX_CLICKS_RESET;
         cfg_ff.click_gap_time  <= CLICK_GAP_TIME_RESET;
         state_ff.phase           <= PH_IDLE;
         state_ff.edge_time       <= 32'd0;
         state_ff.press_start     <= 32'd0;
         state_ff.long_done       <= 1'b0;
         state_ff.repeat_deadline <= 32'd0;
         state_ff.click_count     <= 8'd0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_pin_ff <= in_pin_in;
      in_now_ff <= in_now_in;
      out_ff    <= out_in;
      pend_ff   <= pend_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_ff.event_res;
   assign rsp_click_total   = out_ff.click_total;
   assign rsp_held          = out_ff.held;
   assign rsp_hold_duration = out_ff.hold_duration;
   assign rsp_last          = out_ff.last;

   // ---------------- checks ----------------
   assign out_click = (out_ff.event_res == EV_CLICK) || (out_ff.event_res == EV_MULTI);

   `BDCD_ASSERT(a_pend_behind_out, clock, reset, pend_valid_ff |-> out_valid_ff)
   `BDCD_ASSERT(a_pend_last_order, clock, reset, pend_valid_ff |-> (!out_ff.last && pend_ff.last))
   `BDCD_ASSERT(a_fire_fills_out, clock, reset, fire |=> out_valid_ff)
   `BDCD_NEVER(a_no_click_while_held, clock, reset, out_valid_ff && out_ff.held && out_click)

endmodule

/* dv/tb_button_debounce_click_detector_core.sv */
// self-checking testbench for the button debounce, long-press and click detector core
`timescale 1ns / 1ps

module tb_button_debounce_click_detector_core;
   import bdcd_pkg::*;

   // csr slots past the last register, written to show they change nothing
   localparam logic [2:0] REG_UNUSED_LO = 3'd6;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 10;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_pin_level = 1'b0;
   logic [31:0]               req_now_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [2:0]                rsp_event_res;
   logic [7:0]                rsp_click_total;
   logic                      rsp_held;
   logic [31:0]               rsp_hold_duration;
   logic                      rsp_last;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // predictor copy of the registers and the button state
   cfg_type     regs;
   phase_type   ph = PH_IDLE;
   logic [31:0] edge_ms = '0;
   logic [31:0] press_ms = '0;
   logic        long_seen = 1'b0;
   logic [31:0] rep_deadline_ms = '0;
   logic [7:0]  taps = '0;

   result_type  expected_events[$];
   result_type  want;
   logic [31:0] stamp = '0;
   logic        calm = 1'b0;
   int unsigned fail_count = 0;
   int unsigned polls_sent = 0;
   int unsigned quiet_cycles = 0;

   always #4 clock = ~clock;

   button_debounce_click_detector_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pin_level     (req_pin_level),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_click_total   (rsp_click_total),
      .rsp_held          (rsp_held),
      .rsp_hold_duration (rsp_hold_duration),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // hand the tap count over as a click or multi-click and return to idle
   function automatic void hand_over(output event_type ev, output logic [7:0] n);
      ev = EV_NONE;
      n = '0;
      if (taps == 8'd1) begin
         ev = EV_CLICK;
         n = 8'd1;
      end else if (taps >= 8'd2) begin
         ev = EV_MULTI;
         n = taps;
      end
      taps = '0;
      ph = PH_IDLE;
   endfunction

   function automatic void predict_poll(input logic pin, input logic [31:0] now);
      logic        down;
      logic [31:0] since;
      event_type   ev;
      event_type   ev2;
      logic [7:0]  n;
      logic [7:0]  n2;
      logic        two;
      logic        hold_now;
      result_type  r;
      down = (pin == regs.press_level);
      ev = EV_NONE;
      ev2 = EV_NONE;
      n = '0;
      n2 = '0;
      two = 1'b0;
      case (ph)
         PH_PRESSING: begin
            if (!down) begin
               ph = PH_IDLE;
            end else if (now - edge_ms >= regs.debounce_time) begin
               ph = PH_PRESSED;
               press_ms = now;
               long_seen = 1'b0;
               rep_deadline_ms = (regs.repeat_period != 0) ? now + regs.repeat_period : '0;
               ev = EV_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (!down) begin
               ph = PH_RELEASING;
               edge_ms = now;
            end else begin
               if (!long_seen && regs.long_press_time != 0 &&
                   now - press_ms >= regs.long_press_time) begin
                  long_seen = 1'b1;
                  ev = EV_LONG;
               end
               // a deadline of zero switches repeat off for this hold
               if (!long_seen && regs.repeat_period != 0 && rep_deadline_ms != 0) begin
                  since = now - rep_deadline_ms;
                  if (!since[31]) begin
                     rep_deadline_ms = rep_deadline_ms + regs.repeat_period;
                     ev = EV_REPEAT;
                  end
               end
            end
         end
         PH_RELEASING: begin
            if (down) begin
               ph = PH_PRESSED;
            end else if (now - edge_ms >= regs.debounce_time) begin
               ev = EV_RELEASED;
               if (long_seen) begin
                  taps = '0;
                  ph = PH_IDLE;
               end else begin
                  if (taps != CLICK_COUNT_MAX) taps = taps + 8'd1;
                  if (regs.max_clicks <= 8'd1) begin
                     hand_over(ev2, n2);
                     two = (ev2 != EV_NONE);
                  end else begin
                     ph = PH_WAIT;
                     edge_ms = now;
                  end
               end
            end
         end
         PH_WAIT: begin
            if (down) begin
               ph = PH_PRESSING;
               edge_ms = now;
            end else if (now - edge_ms >= regs.click_gap_time) begin
               hand_over(ev, n);
            end
         end
         default: begin
            if (down) begin
               ph = PH_PRESSING;
               edge_ms = now;
            end
         end
      endcase
      hold_now = (ph == PH_PRESSED) || (ph == PH_RELEASING);
      r.held = hold_now;
      r.hold_duration = hold_now ? now - press_ms : '0;
      r.event_res = ev;
      r.click_total = n;
      r.last = !two;
      expected_events.push_back(r);
      if (two) begin
         r.event_res = ev2;
         r.click_total = n2;
         r.last = 1'b1;
         expected_events.push_back(r);
      end
   endfunction

   function automatic void check_field(input string what, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
                  act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               fail_count++;
               $display("%0t: result item with none expected, actual event %0d", $time,
                        rsp_event_res);
            end else begin
               want = expected_events.pop_front();
               check_field("event_res", 32'(want.event_res), 32'(rsp_event_res));
               check_field("click_total", 32'(want.click_total), 32'(rsp_click_total));
               check_field("held", 32'(want.held), 32'(rsp_held));
               check_field("hold_duration", want.hold_duration, rsp_hold_duration);
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL button_debounce_click_detector_core");
            $finish;
         end
      end
   end

   task automatic send_poll(input logic pin, input logic [31:0] now);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_poll(pin, now);
      polls_sent++;
      req_valid <= 1'b1;
      req_pin_level <= pin;
      req_now_time <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // advance the millisecond clock and poll with the button down or up
   task automatic poll(input logic down, input logic [31:0] dt);
      stamp = stamp + dt;
      send_poll(down ? regs.press_level : ~regs.press_level, stamp);
   endtask

   task automatic tap(input logic [31:0] dt);
      poll(1'b1, dt);
      poll(1'b1, dt);
      poll(1'b0, dt);
      poll(1'b0, dt);
   endtask

   // registers change only once the block has drained
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_PRESS_LEVEL:     regs.press_level = value[0];
         REG_DEBOUNCE_TIME:   regs.debounce_time = value[15:0];
         REG_LONG_PRESS_TIME: regs.long_press_time = value[15:0];
         REG_REPEAT_PERIOD:   regs.repeat_period = value[15:0];
         REG_MAX_CLICKS:      regs.max_clicks = value[7:0];
         REG_CLICK_GAP_TIME:  regs.click_gap_time = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [31:0] debounce, input logic [31:0] long_ms,
                             input logic [31:0] rep_period, input logic [31:0] clicks,
                             input logic [31:0] gap);
      write_reg(REG_DEBOUNCE_TIME, debounce);
      write_reg(REG_LONG_PRESS_TIME, long_ms);
      write_reg(REG_REPEAT_PERIOD, rep_period);
      write_reg(REG_MAX_CLICKS, clicks);
      write_reg(REG_CLICK_GAP_TIME, gap);
   endtask

   // reset settings: bounce, press across the timestamp wrap, click, long hold
   task automatic test_defaults();
      stamp = 32'hFFFF_FFF0;
      poll(1'b1, 0);
      poll(1'b0, 5);
      poll(1'b1, 1);
      poll(1'b1, 10);
      poll(1'b1, 10);
      poll(1'b0, 3);
      poll(1'b1, 2);
      poll(1'b0, 1);
      poll(1'b0, 20);
      poll(1'b1, 7);
      poll(1'b1, 20);
      poll(1'b1, 1500);
      poll(1'b1, 10);
      poll(1'b0, 1);
      poll(1'b0, 25);
   endtask

   task automatic test_repeat();
      set_timing(0, 0, 10, 1, 300);
      poll(1'b1, 5);
      poll(1'b1, 0);
      poll(1'b1, 10);
      poll(1'b1, 3);
      poll(1'b1, 30);
      poll(1'b0, 0);
      poll(1'b0, 0);
      // long press stops the repeats
      write_reg(REG_LONG_PRESS_TIME, 25);
      poll(1'b1, 4);
      poll(1'b1, 0);
      poll(1'b1, 10);
      poll(1'b1, 15);
      poll(1'b1, 10);
      poll(1'b0, 1);
      poll(1'b0, 1);
      // press lands where the repeat deadline wraps to zero
      stamp = 32'hFFFF_FFF6;
      poll(1'b1, 0);
      poll(1'b1, 0);
      poll(1'b1, 20);
      poll(1'b1, 100);
      poll(1'b0, 1);
      poll(1'b0, 1);
   endtask

   task automatic test_multi_click();
      set_timing(2, 0, 0, 3, 40);
      repeat (3) tap(2);
      poll(1'b0, 40);
      tap(2);
      poll(1'b0, 39);
      poll(1'b0, 1);
      // taps past the limit are still counted
      repeat (5) tap(2);
      poll(1'b0, 50);
      // a long hold after two taps drops the count
      write_reg(REG_LONG_PRESS_TIME, 20);
      tap(2);
      tap(2);
      poll(1'b1, 2);
      poll(1'b1, 2);
      poll(1'b1, 20);
      poll(1'b0, 1);
      poll(1'b0, 2);
      poll(1'b0, 100);
      write_reg(REG_MAX_CLICKS, 0);
      tap(2);
   endtask

   task automatic test_active_low();
      write_reg(REG_PRESS_LEVEL, 32'hFFFF_FFFE);
      set_timing(0, 0, 0, 1, 10);
      poll(1'b0, 3);
      tap(1);
      write_reg(REG_UNUSED_LO, 32'h0000_0001);
      write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
      tap(1);
      poll(1'b0, 1);
      write_reg(REG_PRESS_LEVEL, 1);
   endtask

   task automatic test_extremes();
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
      poll(1'b1, 0);
      poll(1'b1, 65534);
      poll(1'b1, 1);
      poll(1'b1, 65535);
      poll(1'b1, 32'hFFFF_FFFF);
      poll(1'b0, 1);
      poll(1'b0, 32'h8000_0000);
      write_reg(REG_LONG_PRESS_TIME, 0);
      poll(1'b1, 0);
      poll(1'b1, 65535);
      poll(1'b1, 65535);
      poll(1'b1, 65535);
      poll(1'b0, 0);
      poll(1'b0, 65535);
      poll(1'b0, 65535);
   endtask

   task automatic random_gesture();
      int unsigned n_down;
      int unsigned n_up;
      int unsigned k;
      n_down = $urandom_range(1, 24);
      n_up = $urandom_range(1, 6);
      // occasional contact bounce in each half of the gesture
      for (k = 0; k < n_down; k++) poll($urandom_range(15) != 0, $urandom_range(0, 12));
      for (k = 0; k < n_up; k++) poll($urandom_range(15) == 0, $urandom_range(0, 12));
      if ($urandom_range(3) == 0) poll(1'b0, $urandom_range(0, 48));
   endtask

   task automatic test_random();
      int unsigned round;
      int unsigned target;
      for (round = 0; round < 5; round++) begin
         calm = (round == 0);
         write_reg(REG_PRESS_LEVEL, $urandom_range(1));
         set_timing($urandom_range(0, 6),
                    ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 120),
                    ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 25),
                    ($urandom_range(5) == 0) ? 255 : $urandom_range(0, 4),
                    $urandom_range(0, 40));
         target = polls_sent + 125;
         while (polls_sent < target) begin
            if ($urandom_range(4) == 0) begin
               if ($urandom_range(3) == 0) stamp = $urandom();
               else stamp = stamp + $urandom_range(0, 12);
               send_poll(1'($urandom_range(1)), stamp);
            end else begin
               random_gesture();
            end
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      regs = '{PRESS_LEVEL_RESET, DEBOUNCE_TIME_RESET, LONG_PRESS_TIME_RESET,
               REPEAT_PERIOD_RESET, MAX_CLICKS_RESET, CLICK_GAP_TIME_RESET};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_repeat();
      test_multi_click();
      test_active_low();
      test_extremes();
      test_random();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS button_debounce_click_detector_core");
      end else begin
         $display("FAIL button_debounce_click_detector_core");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/bdcd_pkg.sv
design/bdcd_fsm.sv
design/button_debounce_click_detector_core.sv
dv/tb_button_debounce_click_detector_core.sv
